// ===== hdl/dksp_pkg.sv =====
// ----------------------------------------------------------------------------
// dksp_pkg
// shared types and constants for the descending key and payload sorter
// ----------------------------------------------------------------------------
package dksp_pkg;

  localparam int unsigned MaxItemsDef = 64;

  localparam int unsigned ScoreW = 15;
  localparam int unsigned PieceW = 5;
  localparam int unsigned CoordW = 4;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic [PieceW-1:0]        piece;
    logic [CoordW-1:0]        target_x;
    logic [CoordW-1:0]        target_y;
  } item_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctrl_t;

endpackage

// ===== hdl/dksp_cell.sv =====
// ----------------------------------------------------------------------------
// dksp_cell
// one slot of the insertion chain: holds an item and its valid bit
// ----------------------------------------------------------------------------
module dksp_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dksp_pkg::cell_ctrl_t ctrl_i,
  input  dksp_pkg::item_t     new_item_i,
  input  dksp_pkg::item_t     prev_item_i,
  input  logic                prev_valid_i,
  input  logic                prev_bump_i,
  input  dksp_pkg::item_t     next_item_i,
  input  logic                next_valid_i,
  output dksp_pkg::item_t     item_o,
  output logic                valid_o,
  output logic                bump_o
);

  dksp_pkg::item_t item_q, item_d;
  logic            valid_q, valid_d;
  logic            bump;

  // new item goes ahead of this slot when the slot is empty or holds a lower score
  assign bump = !valid_q || ($signed(item_q.score) < $signed(new_item_i.score));

  always_comb begin
    item_d  = item_q;
    valid_d = valid_q;
    if (ctrl_i.insert && bump) begin
      if (prev_bump_i) begin
        item_d  = prev_item_i;
        valid_d = prev_valid_i;
      end else begin
        item_d  = new_item_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.shift_out) begin
      item_d  = next_item_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;
  assign bump_o  = bump;

endmodule

// ===== hdl/descending_key_payload_sort.sv =====
// ----------------------------------------------------------------------------
// descending_key_payload_sort
// batch sorter, highest score first, ties kept in arrival order
// ----------------------------------------------------------------------------
// Items enter an insertion chain of MAX_ITEMS cells at one transaction per
// cycle while in_stall_o is low; every cell compares the incoming score with
// its own in the same cycle and either holds, takes the new item or takes its
// upper neighbour. The transaction carrying last_item_i closes the batch:
// in_stall_o then stays high while the chain shifts towards cell 0, one
// result per cycle while out_stall_i is low, with cell 0 driving the result
// ports. Items arriving with the chain full are dropped and overflow_o is
// raised on every result of that batch.
module descending_key_payload_sort #(
  parameter int unsigned MAX_ITEMS = dksp_pkg::MaxItemsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [dksp_pkg::ScoreW-1:0] score_i,
  input  logic [dksp_pkg::PieceW-1:0]        piece_i,
  input  logic [dksp_pkg::CoordW-1:0]        target_x_i,
  input  logic [dksp_pkg::CoordW-1:0]        target_y_i,
  input  logic                               last_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [dksp_pkg::ScoreW-1:0] score_res_o,
  output logic [dksp_pkg::PieceW-1:0]        piece_res_o,
  output logic [dksp_pkg::CoordW-1:0]        target_x_res_o,
  output logic [dksp_pkg::CoordW-1:0]        target_y_res_o,
  output logic                               last_out_o,
  output logic                               overflow_o
);

  dksp_pkg::item_t    new_item;
  dksp_pkg::item_t    cell_item [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_valid;
  logic [MAX_ITEMS-1:0] cell_bump;
  dksp_pkg::cell_ctrl_t ctrl;

  logic emitting_q, emitting_d;
  logic dropped_q, dropped_d;
  logic full;
  logic in_accept;
  logic out_accept;

  assign new_item.score    = score_i;
  assign new_item.piece    = piece_i;
  assign new_item.target_x = target_x_i;
  assign new_item.target_y = target_y_i;

  assign full       = cell_valid[MAX_ITEMS-1];
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_o && !out_stall_i;

  assign ctrl.insert    = in_accept && !full;
  assign ctrl.shift_out = out_accept;

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    dksp_pkg::item_t prev_item, next_item;
    logic            prev_valid, prev_bump, next_valid;

    if (k == 0) begin : g_head
      assign prev_item  = new_item;
      assign prev_valid = 1'b0;
      assign prev_bump  = 1'b0;
    end else begin : g_body
      assign prev_item  = cell_item[k-1];
      assign prev_valid = cell_valid[k-1];
      assign prev_bump  = cell_bump[k-1];
    end

    if (k == MAX_ITEMS - 1) begin : g_tail
      assign next_item  = new_item;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_item  = cell_item[k+1];
      assign next_valid = cell_valid[k+1];
    end

    dksp_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_item_i   (new_item),
      .prev_item_i  (prev_item),
      .prev_valid_i (prev_valid),
      .prev_bump_i  (prev_bump),
      .next_item_i  (next_item),
      .next_valid_i (next_valid),
      .item_o       (cell_item[k]),
      .valid_o      (cell_valid[k]),
      .bump_o       (cell_bump[k])
    );
  end

  always_comb begin
    emitting_d = emitting_q;
    dropped_d  = dropped_q;
    if (in_accept) begin
      if (full) begin
        dropped_d = 1'b1;
      end
      if (last_item_i) begin
        emitting_d = 1'b1;
      end
    end else if (out_accept && last_out_o) begin
      emitting_d = 1'b0;
      dropped_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitting_q <= 1'b0;
      dropped_q  <= 1'b0;
    end else begin
      emitting_q <= emitting_d;
      dropped_q  <= dropped_d;
    end
  end

  assign in_stall_o     = emitting_q;
  assign out_valid_o    = emitting_q && cell_valid[0];
  assign score_res_o    = cell_item[0].score;
  assign piece_res_o    = cell_item[0].piece;
  assign target_x_res_o = cell_item[0].target_x;
  assign target_y_res_o = cell_item[0].target_y;
  assign last_out_o     = !cell_valid[1];
  assign overflow_o     = dropped_q;

  // occupied cells always form an unbroken run from cell 0
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid[MAX_ITEMS-1:1] & ~cell_valid[MAX_ITEMS-2:0]) == '0)
    else $error("gap in occupied cells");

  // head pair stays in descending order
  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> ($signed(cell_item[0].score) >= $signed(cell_item[1].score)))
    else $error("head cells out of order");

  // final result empties the chain and reopens the input
  a_batch_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_accept && last_out_o) |=> (!cell_valid[0] && !emitting_q && !dropped_q))
    else $error("chain not empty after final result");

  // a stored transaction always lands in cell 0 or behind an occupied one
  a_insert_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> cell_valid[0])
    else $error("insert left cell 0 empty");

  // closing a batch always leaves something to emit
  a_close_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_item_i) |=> out_valid_o)
    else $error("closed batch has no result");

endmodule
